// File: hdl/assert_macros.svh
// Assertion macros shared by the sweep and sound DMA block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SRSD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define SRSD_NEVER(lbl, clk, rst_n, cond, msg) \
    `SRSD_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// File: hdl/srsd_pkg.sv
// Types, constants and helper functions of the sweep and sound DMA block.
`default_nettype none

package srsd_pkg;

    // Geometry
    localparam int RAM_DEPTH_DEF = 16384;
    localparam int RAM_SPAN      = 16384;
    localparam int NUM_CH        = 4;
    localparam int SWEEP_CH      = 2;
    localparam int ADDR_W        = 14;
    localparam int DATA_W        = 8;
    localparam int SAMP_W        = 16;
    localparam int PER_W         = 12;
    localparam int HI_W          = 3;
    localparam int CNT_W         = 16;
    localparam int SRC_W         = 24;
    localparam int TIMER_W       = 18;
    localparam int SW_INTV_W     = 15;

    // Operation codes
    localparam logic [1:0] OP_PORT = 2'd0;
    localparam logic [1:0] OP_RAM  = 2'd1;
    localparam logic [1:0] OP_ADV  = 2'd2;

    // Port numbers
    localparam logic [7:0] PORT_PER_FIRST = 8'h80;
    localparam logic [7:0] PORT_PER_LAST  = 8'h87;
    localparam logic [7:0] PORT_VOL1      = 8'h89;
    localparam logic [7:0] PORT_SW_DELTA  = 8'h8C;
    localparam logic [7:0] PORT_SW_INTV   = 8'h8D;
    localparam logic [7:0] PORT_CTRL      = 8'h90;
    localparam logic [7:0] PORT_SRC_LO    = 8'h4A;
    localparam logic [7:0] PORT_SRC_MID   = 8'h4B;
    localparam logic [7:0] PORT_SRC_HI    = 8'h4C;
    localparam logic [7:0] PORT_CNT_LO    = 8'h4E;
    localparam logic [7:0] PORT_CNT_HI    = 8'h4F;
    localparam logic [7:0] PORT_DMA_CTL   = 8'h52;

    localparam logic [10:0] PER_RAW_MAX = 11'h7FF;
    localparam logic [11:0] PER_FULL    = 12'd2048;
    localparam int          SWEEP_EN_BIT = 6;
    localparam int          DMA_GO_BIT   = 7;

    typedef enum logic [1:0] {
        CMD_NOP,
        CMD_PORT,
        CMD_RAM,
        CMD_ADV
    } t_cmd_kind;

    typedef enum logic [3:0] {
        PK_NONE,
        PK_PER_LO,
        PK_PER_HI,
        PK_VOL1,
        PK_SW_DELTA,
        PK_SW_INTV,
        PK_CTRL,
        PK_SRC,
        PK_CNT,
        PK_DMA_CTL
    } t_port_kind;

    typedef struct packed {
        t_cmd_kind          kind;
        t_port_kind         port;
        logic [1:0]         sel;
        logic [ADDR_W-1:0]  addr;
        logic [DATA_W-1:0]  data;
        logic [SAMP_W-1:0]  samples;
    } t_cmd;

    typedef struct packed {
        logic [NUM_CH-1:0][PER_W-1:0] period;
        logic [3:0]                   vol_left;
        logic [3:0]                   vol_right;
        logic                         busy;
        logic [CNT_W-1:0]             left;
        logic [SRC_W-1:0]             addr;
    } t_result;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DMA_CHK,
        ST_DMA_XFER,
        ST_SW_START,
        ST_SW_CHK,
        ST_DONE
    } t_state;

    // Sweep interval in samples for each register value
    typedef logic [SW_INTV_W-1:0] t_intv_tab [256];

    function automatic t_intv_tab build_sw_tab();
        t_intv_tab tab;
        for (int i = 0; i < 256; i++) begin
            tab[i] = SW_INTV_W'(((i + 1) * 1176) / 10);
        end
        return tab;
    endfunction

    localparam t_intv_tab SW_INTV_TAB = build_sw_tab();

    // DMA period in samples for each rate code
    function automatic logic [1:0] dma_period(input logic [1:0] rate);
        logic [1:0] per;
        case (rate)
            2'd0:    per = 2'd3;
            2'd1:    per = 2'd2;
            2'd2:    per = 2'd2;
            default: per = 2'd1;
        endcase
        return per;
    endfunction

    // Raw period decode: the all-ones code stands for the full period
    function automatic logic [PER_W-1:0] dec_period(input logic [HI_W-1:0] hi,
                                                    input logic [7:0] lo);
        logic [10:0] raw;
        raw = {hi, lo};
        return (raw == PER_RAW_MAX) ? PER_FULL : {1'b0, raw};
    endfunction

endpackage

`default_nettype wire

// File: hdl/srsd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module srsd_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word when i_we is set and register one read word each cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hdl/srsd_front.sv
// Front end: accept transactions, classify them and queue them for the back end.
`default_nettype none
`include "assert_macros.svh"

module srsd_front #(
    parameter int RAM_DEPTH = srsd_pkg::RAM_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_push,
    input  wire logic [1:0]                   i_op,
    input  wire logic [srsd_pkg::ADDR_W-1:0]  i_address,
    input  wire logic [srsd_pkg::DATA_W-1:0]  i_data,
    input  wire logic [srsd_pkg::SAMP_W-1:0]  i_samples,
    input  wire logic                         i_hold,
    output logic                              o_full,
    output logic                              o_cmd_valid,
    output srsd_pkg::t_cmd                    o_cmd,
    input  wire logic                         i_cmd_pop
);

    import srsd_pkg::*;

    localparam int          MEM_DEPTH   = (RAM_DEPTH < RAM_SPAN) ? RAM_DEPTH : RAM_SPAN;
    localparam logic [16:0] MEM_DEPTH_W = 17'(MEM_DEPTH);

    t_cmd       w_cmd;
    logic [7:0] w_port;
    logic       w_wr;

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic [1:0] n_cnt;

    // Classify the incoming transaction
    always_comb begin
        w_port        = i_address[7:0];
        w_cmd.kind    = CMD_NOP;
        w_cmd.port    = PK_NONE;
        w_cmd.sel     = i_address[2:1];
        w_cmd.addr    = i_address;
        w_cmd.data    = i_data;
        w_cmd.samples = i_samples;
        unique case (i_op)
            OP_PORT: w_cmd.kind = CMD_PORT;
            OP_RAM:  w_cmd.kind = ({3'b0, i_address} < MEM_DEPTH_W) ? CMD_RAM : CMD_NOP;
            OP_ADV:  w_cmd.kind = CMD_ADV;
            default: w_cmd.kind = CMD_NOP;
        endcase
        unique case (w_port) inside
            [PORT_PER_FIRST:PORT_PER_LAST]: begin
                w_cmd.port = w_port[0] ? PK_PER_HI : PK_PER_LO;
            end
            PORT_VOL1:     w_cmd.port = PK_VOL1;
            PORT_SW_DELTA: w_cmd.port = PK_SW_DELTA;
            PORT_SW_INTV:  w_cmd.port = PK_SW_INTV;
            PORT_CTRL:     w_cmd.port = PK_CTRL;
            PORT_SRC_LO, PORT_SRC_MID, PORT_SRC_HI: begin
                w_cmd.port = PK_SRC;
                w_cmd.sel  = 2'(w_port - PORT_SRC_LO);
            end
            PORT_CNT_LO, PORT_CNT_HI: begin
                w_cmd.port = PK_CNT;
                w_cmd.sel  = {1'b0, w_port[0]};
            end
            PORT_DMA_CTL:  w_cmd.port = PK_DMA_CTL;
            default:       w_cmd.port = PK_NONE;
        endcase
    end

    // Queue handshake
    assign o_full      = (r_cnt == 2'd2) || i_hold;
    assign w_wr        = i_push && !o_full;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign n_cnt       = r_cnt + {1'b0, w_wr} - {1'b0, i_cmd_pop};

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= !r_wp;
            end
            if (i_cmd_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= n_cnt;
        end
    end

    `SRSD_NEVER(a_pop_empty, i_clk, i_rst_n, i_cmd_pop && (r_cnt == 2'd0), "pop from empty queue")
    `SRSD_NEVER(a_cnt_range, i_clk, i_rst_n, r_cnt == 2'd3, "queue fill level out of range")

endmodule

`default_nettype wire

// File: hdl/srsd_back.sv
// Back end: register file, sweep and sound DMA engine, sample RAM.
`default_nettype none
`include "assert_macros.svh"

module srsd_back #(
    parameter int RAM_DEPTH = srsd_pkg::RAM_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cmd_valid,
    input  srsd_pkg::t_cmd  i_cmd,
    output logic            o_cmd_pop,
    output logic            o_clearing,
    output logic            o_res_valid,
    output srsd_pkg::t_result o_res,
    input  wire logic       i_res_ready
);

    import srsd_pkg::*;

    localparam int          MEM_DEPTH   = (RAM_DEPTH < RAM_SPAN) ? RAM_DEPTH : RAM_SPAN;
    localparam int          MEM_AW      = $clog2(MEM_DEPTH);
    localparam logic [16:0] MEM_DEPTH_W = 17'(MEM_DEPTH);
    localparam logic [MEM_AW-1:0] CLR_LAST = MEM_AW'(MEM_DEPTH - 1);

    t_state r_state, n_state;

    // Register file
    logic [7:0]              r_lo     [NUM_CH];
    logic [7:0]              n_lo     [NUM_CH];
    logic [HI_W-1:0]         r_hi     [NUM_CH];
    logic [HI_W-1:0]         n_hi     [NUM_CH];
    logic [PER_W-1:0]        r_period [NUM_CH];
    logic [PER_W-1:0]        n_period [NUM_CH];
    logic [7:0]              r_vol1, n_vol1;
    logic [7:0]              r_delta, n_delta;
    logic [SW_INTV_W-1:0]    r_sw_intv, n_sw_intv;
    logic signed [TIMER_W-1:0] r_sw_cnt, n_sw_cnt;
    logic                    r_sw_en, n_sw_en;
    logic [7:0]              r_src0, n_src0, r_src1, n_src1, r_src2, n_src2;
    logic [7:0]              r_cnt0, n_cnt0, r_cnt1, n_cnt1;
    logic [SRC_W-1:0]        r_src, n_src;
    logic [CNT_W-1:0]        r_left, n_left;
    logic [1:0]              r_dintv, n_dintv;
    logic signed [TIMER_W-1:0] r_dtimer, n_dtimer;
    logic [SAMP_W-1:0]       r_samples, n_samples;
    logic                    r_rd_ok, n_rd_ok;
    logic [MEM_AW-1:0]       r_clr_addr, n_clr_addr;

    // RAM port
    logic              w_ram_we;
    logic [MEM_AW-1:0] w_ram_waddr;
    logic [7:0]        w_ram_wdata;
    logic [7:0]        w_ram_rdata;

    logic              w_dma_active;
    logic              w_dma_due;
    logic              w_sw_on;
    logic              w_sw_due;
    logic [10:0]       w_sweep_per;
    logic signed [TIMER_W-1:0] w_samp_s;

    srsd_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (r_src[MEM_AW-1:0]),
        .o_rdata (w_ram_rdata)
    );

    // Engine conditions
    assign w_dma_active = (r_dintv != 2'd0) && (r_left != '0);
    assign w_dma_due    = r_dtimer[TIMER_W-1] || (r_dtimer == '0);
    assign w_sw_on      = (r_delta != 8'd0) && r_sw_en;
    assign w_sw_due     = r_sw_cnt[TIMER_W-1] || (r_sw_cnt == '0);
    assign w_sweep_per  = 11'(r_period[SWEEP_CH] + {{4{r_delta[7]}}, r_delta});
    assign w_samp_s     = $signed({2'b0, r_samples});

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.kind == CMD_ADV) begin
                        n_state = w_dma_active ? ST_DMA_CHK : ST_SW_START;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DMA_CHK:  n_state = w_dma_due ? ST_DMA_XFER : ST_SW_START;
            ST_DMA_XFER: n_state = (r_left == CNT_W'(1)) ? ST_SW_START : ST_DMA_CHK;
            ST_SW_START: n_state = w_sw_on ? ST_SW_CHK : ST_DONE;
            ST_SW_CHK: begin
                if (!w_sw_due || (r_sw_intv == '0)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Datapath and outputs
    always_comb begin
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_period   = r_period;
        n_vol1     = r_vol1;
        n_delta    = r_delta;
        n_sw_intv  = r_sw_intv;
        n_sw_cnt   = r_sw_cnt;
        n_sw_en    = r_sw_en;
        n_src0     = r_src0;
        n_src1     = r_src1;
        n_src2     = r_src2;
        n_cnt0     = r_cnt0;
        n_cnt1     = r_cnt1;
        n_src      = r_src;
        n_left     = r_left;
        n_dintv    = r_dintv;
        n_dtimer   = r_dtimer;
        n_samples  = r_samples;
        n_rd_ok    = r_rd_ok;
        n_clr_addr = r_clr_addr;
        w_ram_we    = 1'b0;
        w_ram_waddr = r_clr_addr;
        w_ram_wdata = 8'd0;
        o_cmd_pop   = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            ST_CLEAR: begin
                // Sweep zeros through the sample RAM
                w_ram_we   = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
            end
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    n_samples = i_cmd.samples;
                    case (i_cmd.kind)
                        CMD_PORT: begin
                            case (i_cmd.port)
                                PK_PER_LO: begin
                                    n_lo[i_cmd.sel]     = i_cmd.data;
                                    n_period[i_cmd.sel] = dec_period(r_hi[i_cmd.sel],
                                                                     i_cmd.data);
                                end
                                PK_PER_HI: begin
                                    n_hi[i_cmd.sel]     = i_cmd.data[HI_W-1:0];
                                    n_period[i_cmd.sel] = dec_period(i_cmd.data[HI_W-1:0],
                                                                     r_lo[i_cmd.sel]);
                                end
                                PK_VOL1:     n_vol1  = i_cmd.data;
                                PK_SW_DELTA: n_delta = i_cmd.data;
                                PK_SW_INTV: begin
                                    n_sw_intv = SW_INTV_TAB[i_cmd.data];
                                    n_sw_cnt  = $signed({3'b0, SW_INTV_TAB[i_cmd.data]});
                                end
                                PK_CTRL:     n_sw_en = i_cmd.data[SWEEP_EN_BIT];
                                PK_SRC: begin
                                    case (i_cmd.sel)
                                        2'd0:    n_src0 = i_cmd.data;
                                        2'd1:    n_src1 = i_cmd.data;
                                        default: n_src2 = i_cmd.data;
                                    endcase
                                    n_src = {n_src2, n_src1, n_src0};
                                end
                                PK_CNT: begin
                                    if (i_cmd.sel[0]) begin
                                        n_cnt1 = i_cmd.data;
                                    end else begin
                                        n_cnt0 = i_cmd.data;
                                    end
                                    n_left = {n_cnt1, n_cnt0};
                                end
                                PK_DMA_CTL: begin
                                    if (i_cmd.data[DMA_GO_BIT]) begin
                                        n_dintv  = dma_period(i_cmd.data[1:0]);
                                        n_dtimer = $signed({16'b0, dma_period(i_cmd.data[1:0])});
                                    end
                                end
                                default: ;
                            endcase
                        end
                        CMD_RAM: begin
                            w_ram_we    = 1'b1;
                            w_ram_waddr = i_cmd.addr[MEM_AW-1:0];
                            w_ram_wdata = i_cmd.data;
                        end
                        CMD_ADV: begin
                            if (w_dma_active) begin
                                n_dtimer = r_dtimer - $signed({2'b0, i_cmd.samples});
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_DMA_CHK: begin
                // Note whether the byte being read lies inside the RAM
                n_rd_ok = ({3'b0, r_src[ADDR_W-1:0]} < MEM_DEPTH_W);
            end
            ST_DMA_XFER: begin
                // Move one byte into the channel 1 volume
                n_vol1 = r_rd_ok ? w_ram_rdata : 8'd0;
                n_src  = r_src + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    n_dintv = 2'd0;
                end else begin
                    n_dtimer = r_dtimer + $signed({16'b0, r_dintv});
                end
            end
            ST_SW_START: begin
                if (w_sw_on) begin
                    n_sw_cnt = r_sw_cnt - w_samp_s;
                end
            end
            ST_SW_CHK: begin
                // One sweep step per cycle while the counter is due
                if (w_sw_due) begin
                    if (r_sw_intv == '0) begin
                        n_sw_cnt = '0;
                    end else begin
                        n_sw_cnt           = r_sw_cnt + $signed({3'b0, r_sw_intv});
                        n_period[SWEEP_CH] = {1'b0, w_sweep_per};
                        n_lo[SWEEP_CH]     = w_sweep_per[7:0];
                        n_hi[SWEEP_CH]     = w_sweep_per[10:8];
                    end
                end
            end
            ST_DONE: o_res_valid = 1'b1;
            default: ;
        endcase
    end

    // Result snapshot
    always_comb begin
        for (int i = 0; i < NUM_CH; i++) begin
            o_res.period[i] = r_period[i];
        end
        o_res.vol_left  = r_vol1[7:4];
        o_res.vol_right = r_vol1[3:0];
        o_res.busy      = w_dma_active;
        o_res.left      = r_left;
        o_res.addr      = r_src;
    end

    assign o_clearing = (r_state == ST_CLEAR);

    // Control and state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
                r_lo[i]     <= '0;
                r_hi[i]     <= '0;
                r_period[i] <= '0;
            end
            r_vol1    <= '0;
            r_delta   <= '0;
            r_sw_intv <= '0;
            r_sw_cnt  <= '0;
            r_sw_en   <= 1'b0;
            r_src0    <= '0;
            r_src1    <= '0;
            r_src2    <= '0;
            r_cnt0    <= '0;
            r_cnt1    <= '0;
            r_src     <= '0;
            r_left    <= '0;
            r_dintv   <= '0;
            r_dtimer  <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
            r_period   <= n_period;
            r_vol1     <= n_vol1;
            r_delta    <= n_delta;
            r_sw_intv  <= n_sw_intv;
            r_sw_cnt   <= n_sw_cnt;
            r_sw_en    <= n_sw_en;
            r_src0     <= n_src0;
            r_src1     <= n_src1;
            r_src2     <= n_src2;
            r_cnt0     <= n_cnt0;
            r_cnt1     <= n_cnt1;
            r_src      <= n_src;
            r_left     <= n_left;
            r_dintv    <= n_dintv;
            r_dtimer   <= n_dtimer;
        end
    end

    // Working copies without reset
    always_ff @(posedge i_clk) begin
        r_samples <= n_samples;
        r_rd_ok   <= n_rd_ok;
    end

    `SRSD_ASSERT(a_xfer_after_chk, i_clk, i_rst_n, (r_state == ST_DMA_XFER) |-> ($past(r_state) == ST_DMA_CHK), "DMA transfer without a RAM read")
    `SRSD_ASSERT(a_sw_cnt_bound, i_clk, i_rst_n, (r_state == ST_IDLE) |-> (r_sw_cnt <= $signed({3'b0, r_sw_intv})), "sweep counter above its interval")
    `SRSD_NEVER(a_pop_clear, i_clk, i_rst_n, o_cmd_pop && (r_state == ST_CLEAR), "command taken during RAM clear")

endmodule

`default_nettype wire

// File: hdl/sound_register_sweep_dma_core.sv
// Top level of the four-channel sound register block with sweep and sound DMA.
//
//  channel   handshake        payload
//  input     push / full      i_op, i_address, i_data, i_samples
//  result    empty / pop      o_period_ch0..3, o_ch1_vol_*, o_dma_busy, o_dma_left, o_dma_addr
//
// A port write, RAM write or undefined op goes from idle straight to the done state in the back end.
// An advance goes from idle through the DMA check and transfer states, looping for each byte due
// while DMA runs, then to sweep start and, while the sweep is on, to the sweep check state for each step.
// After reset the sample RAM is cleared, one byte a cycle, over min(RAM_DEPTH, 16384)
// bytes, with full held high. A two-entry queue takes new transactions while
// the back end works and one result register waits for pop.
`default_nettype none
`include "assert_macros.svh"

module sound_register_sweep_dma_core #(
    parameter int RAM_DEPTH = srsd_pkg::RAM_DEPTH_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire logic [1:0]                   i_op,
    input  wire logic [srsd_pkg::ADDR_W-1:0]  i_address,
    input  wire logic [srsd_pkg::DATA_W-1:0]  i_data,
    input  wire logic [srsd_pkg::SAMP_W-1:0]  i_samples,
    output logic                              empty,
    input  wire logic                         pop,
    output logic [srsd_pkg::PER_W-1:0]        o_period_ch0,
    output logic [srsd_pkg::PER_W-1:0]        o_period_ch1,
    output logic [srsd_pkg::PER_W-1:0]        o_period_ch2,
    output logic [srsd_pkg::PER_W-1:0]        o_period_ch3,
    output logic [3:0]                        o_ch1_vol_left,
    output logic [3:0]                        o_ch1_vol_right,
    output logic                              o_dma_busy,
    output logic [srsd_pkg::CNT_W-1:0]        o_dma_left,
    output logic [srsd_pkg::SRC_W-1:0]        o_dma_addr
);

    import srsd_pkg::*;

    logic    w_cmd_valid;
    t_cmd    w_cmd;
    logic    w_cmd_pop;
    logic    w_clearing;
    logic    w_res_valid;
    t_result w_res;
    logic    w_res_ready;
    logic    w_load;

    logic    r_out_valid;
    t_result r_out;

    srsd_front #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_op        (i_op),
        .i_address   (i_address),
        .i_data      (i_data),
        .i_samples   (i_samples),
        .i_hold      (w_clearing),
        .o_full      (full),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    srsd_back #(
        .RAM_DEPTH (RAM_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_pop   (w_cmd_pop),
        .o_clearing  (w_clearing),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .i_res_ready (w_res_ready)
    );

    // Result register: free when empty or being popped
    assign w_res_ready = !r_out_valid || pop;
    assign w_load      = w_res_valid && w_res_ready;
    assign empty       = !r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_load || (r_out_valid && !pop);
        end
    end

    // Hold the result payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out <= w_res;
        end
    end

    assign o_period_ch0    = r_out.period[0];
    assign o_period_ch1    = r_out.period[1];
    assign o_period_ch2    = r_out.period[2];
    assign o_period_ch3    = r_out.period[3];
    assign o_ch1_vol_left  = r_out.vol_left;
    assign o_ch1_vol_right = r_out.vol_right;
    assign o_dma_busy      = r_out.busy;
    assign o_dma_left      = r_out.left;
    assign o_dma_addr      = r_out.addr;

    `SRSD_ASSERT(a_pop_drains, i_clk, i_rst_n, (pop && !empty && !w_load) |=> empty, "popped result not removed")
    `SRSD_NEVER(a_busy_count, i_clk, i_rst_n, !empty && o_dma_busy && (o_dma_left == '0), "DMA busy with no bytes left")

endmodule

`default_nettype wire

// File: tb/sound_register_sweep_dma_core_test.sv
// Self-checking testbench for the sweep and sound DMA register block.
`default_nettype none

module sound_register_sweep_dma_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srsd_pkg::*;

    localparam logic [7:0] PORT_VOL0   = 8'h88;
    localparam logic [7:0] PORT_VOL3   = 8'h8B;
    localparam logic [7:0] PORT_STATUS = 8'h91;
    localparam logic [1:0] OP_UNDEF    = 2'd3;
    localparam int         SETTLE      = 400;

    typedef struct packed {
        logic [PER_W-1:0] p0, p1, p2, p3;
        logic [3:0]       vl, vr;
        logic             busy;
        logic [CNT_W-1:0] left;
        logic [SRC_W-1:0] addr;
    } t_snap;

    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        logic [SAMP_W-1:0] samples;
        logic              typed;
        t_snap             want;
    } t_txn;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic [1:0] i_op = '0;
    logic [ADDR_W-1:0] i_address = '0;
    logic [DATA_W-1:0] i_data = '0;
    logic [SAMP_W-1:0] i_samples = '0;
    logic typed_q = 1'b0;
    t_snap want_q = '0;
    wire full, empty, o_dma_busy;
    wire [PER_W-1:0] o_period_ch0, o_period_ch1, o_period_ch2, o_period_ch3;
    wire [3:0] o_ch1_vol_left, o_ch1_vol_right;
    wire [CNT_W-1:0] o_dma_left;
    wire [SRC_W-1:0] o_dma_addr;

    sound_register_sweep_dma_core DUT (.*);

    // Clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state
    logic [7:0]       ports [256];
    logic [7:0]       sram [RAM_SPAN];
    logic [PER_W-1:0] per [NUM_CH];
    logic [7:0]       vol [NUM_CH];
    int               sw_step, sw_intv, sw_cnt;
    logic [SRC_W-1:0] src;
    logic [CNT_W-1:0] cnt;
    int               dma_per, dma_tmr;

    t_txn  stim_q [$];
    t_snap snap_q [$];
    int    errors = 0;
    int    n_taken = 0;
    int    n_checked = 0;
    int    tx_idle = 0;
    int    rx_idle = 0;
    int    hold_cycles = 0;
    bit    in_taken = 1'b0;

    task automatic model_clear();
        foreach (ports[i]) ports[i] = '0;
        foreach (sram[i]) sram[i] = '0;
        foreach (per[i]) begin
            per[i] = '0;
            vol[i] = '0;
        end
        sw_step = 0; sw_intv = 0; sw_cnt = 0;
        src = '0; cnt = '0; dma_per = 0; dma_tmr = 0;
    endtask

    function automatic void port_store(input logic [7:0] p, input logic [7:0] v);
        logic [10:0] raw;
        int ch;
        ports[p] = v;
        if (p >= PORT_PER_FIRST && p <= PORT_PER_LAST) begin
            ch = (p - PORT_PER_FIRST) >> 1;
            raw = {ports[8'h80 + 2*ch + 1][2:0], ports[8'h80 + 2*ch]};
            per[ch] = (raw == PER_RAW_MAX) ? PER_FULL : {1'b0, raw};
        end else if (p >= PORT_VOL0 && p <= PORT_VOL3) begin
            vol[p - PORT_VOL0] = v;
        end else if (p == PORT_SW_DELTA) begin
            sw_step = int'($signed(v));
        end else if (p == PORT_SW_INTV) begin
            sw_intv = ((int'(v) + 1) * 1176) / 10;
            sw_cnt = sw_intv;
        end else if (p == PORT_STATUS) begin
            ports[PORT_STATUS][7] = 1'b1;
        end else if (p >= PORT_SRC_LO && p <= PORT_SRC_HI) begin
            src = {ports[PORT_SRC_HI], ports[PORT_SRC_MID], ports[PORT_SRC_LO]};
        end else if (p == PORT_CNT_LO || p == PORT_CNT_HI) begin
            cnt = {ports[PORT_CNT_HI], ports[PORT_CNT_LO]};
        end else if (p == PORT_DMA_CTL && v[DMA_GO_BIT]) begin
            case (v[1:0])
                2'd0: dma_per = 3;
                2'd3: dma_per = 1;
                default: dma_per = 2;
            endcase
            dma_tmr = dma_per;
        end
    endfunction

    // Advance time: DMA transfers first, then sweep steps
    function automatic void run_samples(input int n);
        logic [10:0] np;
        if (dma_per != 0 && cnt != 0) begin
            dma_tmr -= n;
            while (dma_tmr <= 0) begin
                port_store(PORT_VOL1, sram[src[ADDR_W-1:0]]);
                src = src + 1'b1;
                cnt = cnt - 1'b1;
                if (cnt == 0) begin
                    dma_per = 0;
                    ports[PORT_DMA_CTL][DMA_GO_BIT] = 1'b0;
                    break;
                end
                dma_tmr += dma_per;
            end
        end
        if (sw_step != 0 && ports[PORT_CTRL][SWEEP_EN_BIT]) begin
            sw_cnt -= n;
            while (sw_cnt <= 0) begin
                if (sw_intv <= 0) begin
                    sw_cnt = 0;
                    break;
                end
                sw_cnt += sw_intv;
                np = 11'(int'(per[SWEEP_CH]) + sw_step);
                ports[8'h84] = np[7:0];
                ports[8'h85][2:0] = np[10:8];
                per[SWEEP_CH] = {1'b0, np};
            end
        end
    endfunction

    function automatic t_snap model_apply(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                                          input logic [7:0] d, input logic [SAMP_W-1:0] s);
        t_snap r;
        case (op)
            OP_PORT: port_store(a[7:0], d);
            OP_RAM:  sram[a] = d;
            OP_ADV:  run_samples(int'(s));
            default: ;
        endcase
        r.p0 = per[0]; r.p1 = per[1]; r.p2 = per[2]; r.p3 = per[3];
        r.vl = vol[1][7:4]; r.vr = vol[1][3:0];
        r.busy = (dma_per != 0 && cnt != 0);
        r.left = cnt; r.addr = src;
        return r;
    endfunction

    function automatic void add(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                                input logic [7:0] d, input logic [SAMP_W-1:0] s);
        stim_q.push_back('{op, a, d, s, 1'b0, '0});
    endfunction

    function automatic void add_typed(input logic [1:0] op, input logic [ADDR_W-1:0] a,
                                      input logic [7:0] d, input t_snap w);
        stim_q.push_back('{op, a, d, 16'd0, 1'b1, w});
    endfunction

    // Random transaction, biased towards the sweep and DMA registers
    function automatic void add_random();
        int k;
        logic [7:0] p;
        logic [7:0] d;
        logic [SAMP_W-1:0] s;
        logic [ADDR_W-1:0] a;
        k = $urandom_range(99);
        a = ADDR_W'($urandom);
        d = 8'($urandom);
        if (k < 45) begin
            case ($urandom_range(11))
                0, 1: p = PORT_PER_FIRST + 8'($urandom_range(7));
                2:  p = PORT_VOL0 + 8'($urandom_range(3));
                3:  p = PORT_SW_DELTA;
                4:  p = PORT_SW_INTV;
                5:  p = PORT_CTRL;
                6:  p = PORT_SRC_LO + 8'($urandom_range(2));
                7:  p = PORT_CNT_LO;
                8:  begin
                        p = PORT_CNT_HI;
                        if ($urandom_range(99) > 2) d = 8'($urandom_range(1));
                    end
                9:  begin
                        p = PORT_DMA_CTL;
                        d[7] = ($urandom_range(3) != 0);
                    end
                10: p = PORT_STATUS;
                default: p = 8'($urandom);
            endcase
            if (p == PORT_CTRL) d[SWEEP_EN_BIT] = ($urandom_range(3) != 0);
            if (p == PORT_SW_INTV) d = 8'($urandom_range(15));
            add(OP_PORT, {a[ADDR_W-1:8], p}, d, SAMP_W'($urandom));
        end else if (k < 65) begin
            add(OP_RAM, a, d, SAMP_W'($urandom));
        end else if (k < 95) begin
            k = $urandom_range(99);
            if (k < 2) s = SAMP_W'($urandom);
            else if (k < 3) s = '1;
            else if (k < 70) s = SAMP_W'($urandom_range(8));
            else s = SAMP_W'($urandom_range(600));
            add(OP_ADV, a, d, s);
        end else begin
            add(OP_UNDEF, a, d, SAMP_W'($urandom));
        end
    endfunction

    // Sender: hold the transaction until taken, then offer the next or idle
    initial begin
        t_txn t;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (!(push && !in_taken)) begin
                in_taken = 1'b0;
                if (stim_q.size() == 0 || $urandom_range(99) < tx_idle) begin
                    push <= 1'b0;
                end else begin
                    t = stim_q.pop_front();
                    push <= 1'b1;
                    i_op <= t.op; i_address <= t.addr;
                    i_data <= t.data; i_samples <= t.samples;
                    typed_q <= t.typed; want_q <= t.want;
                end
            end
        end
    end

    // Receiver: random pop, with an optional long hold-off
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_cycles > 0) begin
                hold_cycles--;
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= rx_idle);
            end
        end
    end

    // Accept input transactions and check results
    always @(posedge i_clk) begin
        t_snap pred, got;
        if (i_rst_n && push && !full) begin
            in_taken = 1'b1;
            n_taken++;
            pred = model_apply(i_op, i_address, i_data, i_samples);
            snap_q.push_back(typed_q ? want_q : pred);
        end
        if (i_rst_n && pop && !empty) begin
            got = '{o_period_ch0, o_period_ch1, o_period_ch2, o_period_ch3,
                    o_ch1_vol_left, o_ch1_vol_right, o_dma_busy, o_dma_left, o_dma_addr};
            n_checked++;
            if (snap_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result %h", $realtime, got);
            end else begin
                pred = snap_q.pop_front();
                if (got !== pred) begin
                    errors++;
                    $display("%0t: mismatch exp p=%h/%h/%h/%h vol=%h/%h busy=%b left=%h addr=%h",
                             $realtime, pred.p0, pred.p1, pred.p2, pred.p3, pred.vl, pred.vr,
                             pred.busy, pred.left, pred.addr);
                    $display("%0t:          act p=%h/%h/%h/%h vol=%h/%h busy=%b left=%h addr=%h",
                             $realtime, got.p0, got.p1, got.p2, got.p3, got.vl, got.vr,
                             got.busy, got.left, got.addr);
                end
            end
        end
    end

    task automatic drain();
        while (stim_q.size() != 0 || push || snap_q.size() != 0) @(posedge i_clk);
    endtask

    // Main sequence
    initial begin
        t_snap w;
        model_clear();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: reset state, period extremes, volumes, sweep and DMA corners
        w = '0;
        add_typed(OP_UNDEF, '1, '1, w);
        w.p0 = 12'h0FF;
        add_typed(OP_PORT, {6'h3F, PORT_PER_FIRST}, 8'hFF, w);
        w.p0 = PER_FULL;
        add_typed(OP_PORT, 14'h0081, 8'hFF, w);
        add(OP_PORT, 14'h0086, 8'hFF, 16'h0);
        add(OP_PORT, 14'h0087, 8'h07, 16'h0);
        add(OP_PORT, {6'h15, PORT_VOL1}, 8'hA5, 16'h0);
        add(OP_PORT, PORT_SW_DELTA, 8'h01, 16'h0);
        add(OP_PORT, PORT_CTRL, 8'h40, 16'h0);
        add(OP_ADV, 14'h0, 8'h0, 16'd500);          // sweep with no interval yet
        add(OP_PORT, PORT_SW_INTV, 8'h00, 16'h0);
        add(OP_PORT, 14'h0084, 8'hFD, 16'h0);
        add(OP_PORT, 14'h0085, 8'hFF, 16'h0);
        add(OP_ADV, 14'h0, 8'h0, 16'd234);          // two steps up to the all-ones code
        add(OP_PORT, PORT_SW_DELTA, 8'h80, 16'h0);
        add(OP_ADV, 14'h0, 8'h0, 16'd117);
        add(OP_PORT, PORT_STATUS, 8'h00, 16'h0);
        add(OP_RAM, 14'h3FFF, 8'h9C, 16'h0);
        add(OP_RAM, 14'h0000, 8'h37, 16'h0);
        add(OP_PORT, PORT_SRC_LO, 8'hFF, 16'h0);
        add(OP_PORT, PORT_SRC_MID, 8'hFF, 16'h0);
        add(OP_PORT, PORT_SRC_HI, 8'hFF, 16'h0);   // source wraps to zero
        add(OP_PORT, PORT_CNT_LO, 8'h02, 16'h0);
        add(OP_PORT, PORT_DMA_CTL, 8'h83, 16'h0);
        add(OP_PORT, PORT_DMA_CTL, 8'h01, 16'h0);  // no go bit: keeps running
        add(OP_ADV, 14'h0, 8'h0, 16'hFFFF);
        add(OP_ADV, 14'h0, 8'h0, 16'h0);
        drain();

        // Random phases: slow receiver, then slow sender with a receiver hold-off, then no idling
        tx_idle = 34; rx_idle = 73;
        repeat (450) add_random();
        drain();
        tx_idle = 73; rx_idle = 34;
        hold_cycles = 300;
        tx_idle = 0;
        repeat (40) add_random();
        while (hold_cycles > 0) @(posedge i_clk);
        tx_idle = 73;
        repeat (410) add_random();
        drain();
        tx_idle = 0; rx_idle = 0;
        repeat (450) add_random();
        drain();
        repeat (SETTLE) @(posedge i_clk);
        if (snap_q.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $realtime, snap_q.size());
        end
        $display("Run covered %0d transactions and %0d results over three idling mixes,",
                 n_taken, n_checked);
        $display("with a long receiver hold-off, sweep wrap and DMA end and wrap cases.");
        if (errors == 0) begin
            $display("PASS sound_register_sweep_dma_core");
        end else begin
            $display("FAIL sound_register_sweep_dma_core");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #200ms;
        $display("FAIL sound_register_sweep_dma_core");
        $finish;
    end

endmodule

`default_nettype wire
